FILE: hdl/scpu_pkg.sv
// Shared types and constants of the 16-bit execute step.
`timescale 1ns / 1ps

package scpu_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned ImmW     = 6;
  localparam int unsigned OutAddrW = 9;

  localparam logic [RegIdxW-1:0] ImmSelReg = 3'd7;

  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_MOV  = 4'd1,
    OP_ADD  = 4'd2,
    OP_SUB  = 4'd3,
    OP_JMP  = 4'd8,
    OP_JZ   = 4'd9,
    OP_HALT = 4'd12
  } opcode_e;

  typedef struct packed {
    opcode_e              op;
    logic [RegIdxW-1:0]   r1;
    logic [RegIdxW-1:0]   r2;
    logic [ImmW-1:0]      imm;
  } instr_t;

  typedef struct packed {
    logic carry;
    logic negative;
    logic zero;
  } flags_t;

  typedef struct packed {
    logic [OutAddrW-1:0] next_address;
    logic                write_enable;
    logic [RegIdxW-1:0]  write_index;
    logic [DataW-1:0]    write_value;
    flags_t              flags;
    logic                halted;
  } result_t;

endpackage

FILE: hdl/scpu_in_if.sv
// Instruction channel of the execute step.
`timescale 1ns / 1ps

interface scpu_in_if import scpu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

FILE: hdl/scpu_out_if.sv
// Result channel of the execute step.
`timescale 1ns / 1ps

interface scpu_out_if import scpu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OutAddrW-1:0] next_address;
  logic                write_enable;
  logic [RegIdxW-1:0]  write_index;
  logic [DataW-1:0]    write_value;
  logic                zero_flag;
  logic                negative_flag;
  logic                carry_flag;
  logic                halted;

  modport source (
    output valid, output next_address, output write_enable, output write_index,
    output write_value, output zero_flag, output negative_flag, output carry_flag,
    output halted, input ready
  );
  modport sink (
    input valid, input next_address, input write_enable, input write_index,
    input write_value, input zero_flag, input negative_flag, input carry_flag,
    input halted, output ready
  );
endinterface

FILE: hdl/scpu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module scpu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/scpu_exec.sv
// Instruction decode, ALU and next-state logic of the execute step.
`timescale 1ns / 1ps

module scpu_exec import scpu_pkg::*; #(
  parameter int unsigned ADDRESS_WIDTH = 9
) (
  input  logic [DataW-1:0]         instruction_i,
  input  logic [DataW-1:0]         op_x_i,
  input  logic [DataW-1:0]         op_y_i,
  input  logic [ADDRESS_WIDTH-1:0] addr_i,
  input  flags_t                   flags_i,
  input  logic                     stopped_i,
  output logic [ADDRESS_WIDTH-1:0] addr_o,
  output flags_t                   flags_o,
  output logic                     stopped_o,
  output result_t                  result_o
);

  instr_t             ins;
  logic [DataW-1:0]   alu_a;
  logic [DataW-1:0]   alu_b;
  logic [DataW:0]     sum;
  logic [DataW-1:0]   alu_r;
  flags_t             alu_flags;
  logic               we;
  logic [DataW-1:0]   wval;

  assign ins = instr_t'(instruction_i);

  always_comb begin
    alu_a = (ins.op == OP_SUB) ? ~op_x_i : op_x_i;
    alu_b = (ins.op == OP_ADD && ins.r2 == ImmSelReg) ? DataW'(ins.imm) : op_y_i;
    sum = {1'b0, alu_a} + {1'b0, alu_b};
    alu_r = (ins.op == OP_SUB) ? ~sum[DataW-1:0] : sum[DataW-1:0];
    alu_flags.zero = (alu_r == '0);
    alu_flags.negative = alu_r[DataW-1];
    alu_flags.carry = sum[DataW];
  end

  always_comb begin
    addr_o = addr_i + ADDRESS_WIDTH'(1);
    flags_o = flags_i;
    stopped_o = stopped_i;
    we = 1'b0;
    wval = '0;
    case (ins.op)
      OP_MOV: begin
        we = 1'b1;
        wval = DataW'(ins.imm);
      end
      OP_ADD, OP_SUB: begin
        we = 1'b1;
        wval = alu_r;
        flags_o = alu_flags;
      end
      OP_JMP: begin
        addr_o = ADDRESS_WIDTH'(ins.imm);
      end
      OP_JZ: begin
        if (flags_i.zero) begin
          addr_o = ADDRESS_WIDTH'(ins.imm);
        end
      end
      OP_HALT: begin
        stopped_o = 1'b1;
      end
      default: begin
      end
    endcase
    if (stopped_i) begin
      addr_o = addr_i;
      flags_o = flags_i;
      stopped_o = 1'b1;
      we = 1'b0;
      wval = '0;
    end
  end

  always_comb begin
    result_o.next_address = OutAddrW'(addr_o);
    result_o.write_enable = we;
    result_o.write_index = we ? ins.r1 : '0;
    result_o.write_value = wval;
    result_o.flags = flags_o;
    result_o.halted = stopped_o;
  end

endmodule

FILE: hdl/sixteen_bit_cpu_execute_step.sv
// Top level of the 16-bit execute step: pipeline, register file and state.
//
// The block takes one instruction word per transaction on in_i and returns one
// result per transaction on out_o, in order: the next fetch address, the
// register write it made, the stored ALU flags and the halt mark.
// The instruction is captured in an input register while both register-file
// operands are read from two copies of an 8 x 16 RAM; once the result register
// is free, the block decodes, runs the adder and loads the result register and
// the machine state. A new instruction is accepted every cycle while the
// receiver keeps ready high. A write made in the cycle an operand is read is
// bypassed from the last-write register.
// Reset clears the instruction address, the flags, the halt mark and the
// register-file valid bits, so every register reads as zero until written.
// When the receiver holds ready low, the result register holds its
// transaction, the input register fills, and in_i.ready then goes low.
// After HALT every further instruction leaves the state untouched.
`timescale 1ns / 1ps

module sixteen_bit_cpu_execute_step import scpu_pkg::*; #(
  parameter int unsigned ADDRESS_WIDTH = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  scpu_in_if.sink       in_i,
  scpu_out_if.source    out_o
);

  logic                     s1_valid_q;
  logic [DataW-1:0]         instr_q;
  logic                     out_valid_q;
  result_t                  res_q;
  logic [ADDRESS_WIDTH-1:0] addr_q;
  flags_t                   flags_q;
  logic                     stopped_q;
  logic [NumRegs-1:0]       rf_valid_q;
  logic                     lw_valid_q;
  logic [RegIdxW-1:0]       lw_idx_q;
  logic [DataW-1:0]         lw_val_q;

  logic [ADDRESS_WIDTH-1:0] addr_d;
  flags_t                   flags_d;
  logic                     stopped_d;
  result_t                  res_d;

  logic                     out_free;
  logic                     exec_go;
  logic                     in_acc;
  logic                     rf_we;
  instr_t                   in_ins;
  instr_t                   s1_ins;
  logic [DataW-1:0]         ram_x;
  logic [DataW-1:0]         ram_y;
  logic [DataW-1:0]         op_x;
  logic [DataW-1:0]         op_y;

  assign out_free = !out_valid_q || out_o.ready;
  assign exec_go = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc = in_i.valid && in_i.ready;
  assign rf_we = exec_go && res_d.write_enable;

  assign in_ins = instr_t'(in_i.instruction);
  assign s1_ins = instr_t'(instr_q);

  scpu_ram #(
    .WIDTH(DataW),
    .DEPTH(NumRegs)
  ) u_rf_x (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(res_d.write_index),
    .wdata_i(res_d.write_value),
    .re_i   (in_acc),
    .raddr_i(in_ins.r1),
    .rdata_o(ram_x)
  );

  scpu_ram #(
    .WIDTH(DataW),
    .DEPTH(NumRegs)
  ) u_rf_y (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(res_d.write_index),
    .wdata_i(res_d.write_value),
    .re_i   (in_acc),
    .raddr_i(in_ins.r2),
    .rdata_o(ram_y)
  );

  always_comb begin
    if (lw_valid_q && lw_idx_q == s1_ins.r1) begin
      op_x = lw_val_q;
    end else begin
      op_x = rf_valid_q[s1_ins.r1] ? ram_x : '0;
    end
    if (lw_valid_q && lw_idx_q == s1_ins.r2) begin
      op_y = lw_val_q;
    end else begin
      op_y = rf_valid_q[s1_ins.r2] ? ram_y : '0;
    end
  end

  scpu_exec #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_exec (
    .instruction_i(instr_q),
    .op_x_i       (op_x),
    .op_y_i       (op_y),
    .addr_i       (addr_q),
    .flags_i      (flags_q),
    .stopped_i    (stopped_q),
    .addr_o       (addr_d),
    .flags_o      (flags_d),
    .stopped_o    (stopped_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      addr_q <= '0;
      flags_q <= '0;
      stopped_q <= 1'b0;
      rf_valid_q <= '0;
      lw_valid_q <= 1'b0;
      lw_idx_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (exec_go) begin
        s1_valid_q <= 1'b0;
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
        addr_q <= addr_d;
        flags_q <= flags_d;
        stopped_q <= stopped_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we) begin
        rf_valid_q[res_d.write_index] <= 1'b1;
        lw_valid_q <= 1'b1;
        lw_idx_q <= res_d.write_index;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      instr_q <= in_i.instruction;
    end
    if (exec_go) begin
      res_q <= res_d;
    end
    if (rf_we) begin
      lw_val_q <= res_d.write_value;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.next_address = res_q.next_address;
  assign out_o.write_enable = res_q.write_enable;
  assign out_o.write_index = res_q.write_index;
  assign out_o.write_value = res_q.write_value;
  assign out_o.zero_flag = res_q.flags.zero;
  assign out_o.negative_flag = res_q.flags.negative;
  assign out_o.carry_flag = res_q.flags.carry;
  assign out_o.halted = res_q.halted;

endmodule

FILE: test/tb_sixteen_bit_cpu_execute_step.sv
// Self-checking testbench of the 16-bit execute step, with a behavioral predictor and scoreboard.
`timescale 1ns / 1ps

module tb_sixteen_bit_cpu_execute_step;
  import scpu_pkg::*;

  localparam int unsigned AddrW      = 9;
  localparam int unsigned CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;

  scpu_in_if  in_bus ();
  scpu_out_if out_bus ();

  sixteen_bit_cpu_execute_step #(
    .ADDRESS_WIDTH(AddrW)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Architectural state of the predictor.
  logic [DataW-1:0] cpu_regs [NumRegs];
  logic [AddrW-1:0] cpu_pc;
  flags_t           cpu_flags;
  logic             cpu_halted;

  result_t     exec_results_q [$];
  int unsigned err_count;
  int unsigned clk_ticks;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_writes;
  int unsigned n_branches_taken;
  int          hold_cycles;
  bit          src_idle_on;
  bit          sink_idle_on;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    clk_ticks++;
    if (clk_ticks > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic flags_t flags_of(input logic [DataW-1:0] value, input logic carry);
    flags_t f;
    f.zero     = (value == '0);
    f.negative = value[DataW-1];
    f.carry    = carry;
    return f;
  endfunction

  // Executes one instruction on the predictor state and returns the result it reports.
  function automatic result_t execute_instr(input logic [DataW-1:0] word);
    instr_t           ins;
    result_t          res;
    logic [DataW-1:0] operand;
    logic [DataW:0]   total;
    logic [AddrW-1:0] target;
    ins = word;
    res = '0;
    if (!cpu_halted) begin
      target = cpu_pc + AddrW'(1);
      case (ins.op)
        OP_MOV: begin
          res.write_enable = 1'b1;
          res.write_index  = ins.r1;
          res.write_value  = {{(DataW-ImmW){1'b0}}, ins.imm};
        end
        OP_ADD: begin
          operand = (ins.r2 == ImmSelReg) ? {{(DataW-ImmW){1'b0}}, ins.imm} : cpu_regs[ins.r2];
          total = {1'b0, cpu_regs[ins.r1]} + {1'b0, operand};
          res.write_enable = 1'b1;
          res.write_index  = ins.r1;
          res.write_value  = total[DataW-1:0];
          cpu_flags = flags_of(total[DataW-1:0], total[DataW]);
        end
        OP_SUB: begin
          total = {1'b0, ~cpu_regs[ins.r1]} + {1'b0, cpu_regs[ins.r2]};
          res.write_enable = 1'b1;
          res.write_index  = ins.r1;
          res.write_value  = ~total[DataW-1:0];
          cpu_flags = flags_of(~total[DataW-1:0], total[DataW]);
        end
        OP_JMP: begin
          target = AddrW'(ins.imm);
          n_branches_taken++;
        end
        OP_JZ: begin
          if (cpu_flags.zero) begin
            target = AddrW'(ins.imm);
            n_branches_taken++;
          end
        end
        OP_HALT: cpu_halted = 1'b1;
        default: ;
      endcase
      if (res.write_enable) begin
        cpu_regs[res.write_index] = res.write_value;
        n_writes++;
      end
      cpu_pc = target;
    end
    res.next_address = OutAddrW'(cpu_pc);
    res.flags        = cpu_flags;
    res.halted       = cpu_halted;
    return res;
  endfunction

  function automatic logic [DataW-1:0] encode(input logic [3:0] op, input logic [2:0] r1,
                                              input logic [2:0] r2, input logic [5:0] imm);
    return {op, r1, r2, imm};
  endfunction

  function automatic logic [DataW-1:0] random_instr(input bit with_branches,
                                                    input bit any_op);
    logic [3:0]       op;
    logic [DataW-1:0] word;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (any_op) begin
      op = 4'($urandom_range(0, 15));
    end else if (pick < 20) begin
      op = OP_MOV;
    end else if (pick < 50) begin
      op = OP_ADD;
    end else if (pick < 75) begin
      op = OP_SUB;
    end else if (with_branches && pick < 80) begin
      op = OP_JMP;
    end else if (with_branches && pick < 90) begin
      op = OP_JZ;
    end else begin
      do op = 4'($urandom_range(0, 15));
      while (op inside {OP_MOV, OP_ADD, OP_SUB, OP_JMP, OP_JZ, OP_HALT});
    end
    word = 16'($urandom);
    word[15:12] = op;
    return word;
  endfunction

  task automatic issue_instr(input logic [DataW-1:0] word);
    while (src_idle_on && $urandom_range(0, 99) < 7) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.instruction <= word;
    do @(posedge clk_i);
    while (!in_bus.ready);
    exec_results_q.push_back(execute_instr(word));
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (exec_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_bus.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_bus.ready <= !(sink_idle_on && $urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (exec_results_q.size() == 0) begin
        $error("Result transaction arrived with no instruction outstanding.");
        err_count++;
      end else begin
        want = exec_results_q.pop_front();
        n_checked++;
        check_field("next_address", want.next_address, out_bus.next_address);
        check_field("write_enable", want.write_enable, out_bus.write_enable);
        check_field("write_index", want.write_index, out_bus.write_index);
        check_field("write_value", want.write_value, out_bus.write_value);
        check_field("zero_flag", want.flags.zero, out_bus.zero_flag);
        check_field("negative_flag", want.flags.negative, out_bus.negative_flag);
        check_field("carry_flag", want.flags.carry, out_bus.carry_flag);
        check_field("halted", want.halted, out_bus.halted);
      end
    end
  end

  task automatic test_directed_ops();
    issue_instr(encode(OP_MOV, 3'd0, 3'd0, 6'h3F));
    issue_instr(encode(OP_MOV, 3'd6, 3'd0, 6'd1));
    issue_instr(encode(OP_ADD, 3'd0, ImmSelReg, 6'h3F));
    issue_instr(encode(OP_ADD, 3'd1, 3'd0, 6'd0));
    issue_instr(encode(OP_SUB, 3'd2, 3'd0, 6'd0));
    issue_instr(encode(OP_SUB, 3'd3, 3'd3, 6'd0));
    issue_instr(encode(OP_JZ, 3'd0, 3'd0, 6'd10));
    issue_instr(encode(OP_MOV, 3'd7, 3'd0, 6'h3F));
    issue_instr(encode(OP_SUB, 3'd0, 3'd7, 6'd0));
    issue_instr(encode(OP_SUB, 3'd5, 3'd6, 6'd0));
    issue_instr(encode(OP_ADD, 3'd5, ImmSelReg, 6'd1));
    issue_instr(encode(OP_JZ, 3'd0, 3'd0, 6'd40));
    issue_instr(encode(OP_ADD, 3'd2, 3'd2, 6'd0));
    issue_instr(encode(OP_JZ, 3'd0, 3'd0, 6'd3));
    issue_instr(encode(OP_JMP, 3'd7, 3'd7, 6'h3F));
    issue_instr(encode(OP_JMP, 3'd0, 3'd0, 6'd0));
    for (int v = 0; v < 16; v++) begin
      if (!(4'(v) inside {OP_MOV, OP_ADD, OP_SUB, OP_JMP, OP_JZ, OP_HALT})) begin
        issue_instr(encode(4'(v), 3'(v), 3'(v + 3), 6'(v * 5)));
      end
    end
  endtask

  // A long run without branches carries the address past its top and back to zero.
  task automatic test_address_wrap();
    repeat (520) issue_instr(random_instr(1'b0, 1'b0));
  endtask

  task automatic test_random_program();
    repeat (600) issue_instr(random_instr(1'b1, 1'b0));
  endtask

  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (200) issue_instr(random_instr(1'b1, 1'b0));
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_result_backpressure();
    hold_cycles = 60;
    repeat (40) issue_instr(random_instr(1'b1, 1'b0));
  endtask

  task automatic test_drain_pause();
    repeat (30) issue_instr(random_instr(1'b1, 1'b0));
    wait_drained();
    repeat (30) issue_instr(random_instr(1'b1, 1'b0));
  endtask

  task automatic test_halt_freeze();
    issue_instr(encode(OP_HALT, 3'd0, 3'd0, 6'd0));
    issue_instr(encode(OP_MOV, 3'd4, 3'd0, 6'h2A));
    issue_instr(encode(OP_JMP, 3'd0, 3'd0, 6'd5));
    repeat (20) issue_instr(random_instr(1'b1, 1'b1));
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.instruction = '0;
    out_bus.ready      = 1'b0;
    for (int i = 0; i < NumRegs; i++) cpu_regs[i] = '0;
    cpu_pc           = '0;
    cpu_flags        = '0;
    cpu_halted       = 1'b0;
    err_count        = 0;
    clk_ticks        = 0;
    n_sent           = 0;
    n_checked        = 0;
    n_writes         = 0;
    n_branches_taken = 0;
    hold_cycles      = 0;
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_address_wrap();
    test_random_program();
    test_full_rate();
    test_result_backpressure();
    test_drain_pause();
    test_halt_freeze();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Executed %0d instructions and checked %0d results.", n_sent, n_checked);
    $display("Register writes: %0d, branches taken: %0d, ending in the halted state.",
             n_writes, n_branches_taken);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
